// ===== hw/rtl/rsch_pkg.sv =====
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types, codes and helpers for the ray/sphere closest-hit block.
// ----------------------------------------------------------------------------
package rsch_pkg;

   // Sphere table depth; slot and index fields are sized for it
   localparam int MAX_SPHERES = 16;

   // Accumulator width: three scaled products plus headroom for sign
   localparam int ACC_W = 66;

   // Request action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TRACE = 1'b1;

   // One sphere table entry
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [30:0]        radius;
   } sphere_type;

   // Control and status of an iterative unit
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // Trace sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_MUL,
      ST_A_ACC,
      ST_RD,
      ST_OC,
      ST_H_MUL,
      ST_H_ACC,
      ST_C_MUL,
      ST_C_ACC,
      ST_R_MUL,
      ST_R_ACC,
      ST_D_MUL1,
      ST_D_ACC1,
      ST_D_MUL2,
      ST_D_ACC2,
      ST_SQ_RUN,
      ST_T_DIV,
      ST_NEXT,
      ST_F_RD,
      ST_F_CEN,
      ST_P_MUL,
      ST_P_ACC,
      ST_N_SUB,
      ST_L_MUL,
      ST_L_ACC,
      ST_L_SQ,
      ST_NRM,
      ST_NRM_DIV,
      ST_OUT
   } state_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return 32'(v);
      end
   endfunction

endpackage

// ===== hw/rtl/rsch_if.sv =====
// ----------------------------------------------------------------------------
// rsch interfaces
// Valid/ready channels for requests, responses and the count register.
// ----------------------------------------------------------------------------

// Request channel: sphere load or ray trace
interface rsch_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [3:0]         slot;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic [30:0]        sphere_size;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;

   modport source (
      output valid, action, slot, center_x, center_y, center_z, sphere_size,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      input  ready
   );
   modport sink (
      input  valid, action, slot, center_x, center_y, center_z, sphere_size,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      output ready
   );
endinterface

// Response channel: closest hit of one trace
interface rsch_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [3:0]         hit_index;
   logic signed [31:0] hit_distance;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] normal_x;
   logic signed [31:0] normal_y;
   logic signed [31:0] normal_z;

   modport source (
      output valid, hit, hit_index, hit_distance, point_x, point_y, point_z,
             normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_index, hit_distance, point_x, point_y, point_z,
             normal_x, normal_y, normal_z,
      output ready
   );
endinterface

// Register write channel: sphere count
interface rsch_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/rsch_ram.sv =====
// ----------------------------------------------------------------------------
// rsch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rsch_isqrt.sv =====
// ----------------------------------------------------------------------------
// rsch_isqrt
// Iterative integer square root, 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module rsch_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  rsch_pkg::unit_ctl_type ctl,
   input  logic [63:0]            radicand,
   output rsch_pkg::unit_sts_type sts,
   output logic [31:0]            root
);

   logic [63:0] rad_ff,  rad_in;
   logic [33:0] rem_ff,  rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff,  cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        fits;

   // One restoring step: bring down two bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[63:62]};
      trial  = {2'b00, root_ff, 2'b01};
      fits   = rem_sh >= trial;
   end

   // Sequence the 32 steps
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[61:0], 2'b00};
         rem_in  = fits ? 34'(rem_sh - trial) : rem_sh[33:0];
         root_in = {root_ff[30:0], fits};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

// ===== hw/rtl/rsch_div.sv =====
// ----------------------------------------------------------------------------
// rsch_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsch_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsch_pkg::unit_ctl_type ctl,
   input  logic [NUM_W-1:0]       numer,
   input  logic [DEN_W-1:0]       denom,
   output rsch_pkg::unit_sts_type sts,
   output logic [NUM_W-1:0]       quot
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic [NUM_W-1:0] num_ff,  num_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_sh;
   logic             fits;

   // Bring down the next dividend bit and try the divisor
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   // Sequence NUM_W steps; quotient bits shift in behind the dividend
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = num_ff;

endmodule

// ===== hw/rtl/ray_sphere_closest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Closest-hit ray/sphere intersection over a loadable sphere table.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : a load transaction (action=0) writes one sphere slot; a trace
//             transaction (action=1) tests the ray against the first
//             sphere_count slots and produces one response.
//   rsp_ch  : hit flag, slot, distance, hit point and unit normal, Q format
//             with FRAC_BITS fraction bits; a miss returns distance -1.0.
//   csr_ch  : writes sphere_count, always ready; write it only when idle.
// Datapath: one shared 32x32 multiplier with an accumulator, a 32-step
//   square-root unit and a (32+FRAC_BITS)-step divider do all the work.
//   A trace first forms d.d once, then for each tested sphere reads the
//   table, forms h, c and the discriminant by multiply/accumulate steps,
//   takes the root of a non-negative discriminant, divides for a positive
//   distance, and at the end computes the point and normal of the hit.
//   req_ch is ready only while no trace is in progress.
// Reset clears the sequencer, the count and the response valid flag; the
//   sphere table is not cleared and slots must be loaded before use.
// A stalled response holds in its output register; loads still proceed,
//   and a following trace waits at its end until the response is taken.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit #(
   parameter int FRAC_BITS   = 16
) (
   input logic        clock,
   input logic        reset,
   rsch_req_if.sink   req_ch,
   rsch_rsp_if.source rsp_ch,
   rsch_csr_if.sink   csr_ch
);

   localparam int MAX_SPHERES = rsch_pkg::MAX_SPHERES;
   localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int ACC_W = rsch_pkg::ACC_W;
   localparam logic signed [31:0] MISS_DIST = -(32'sd1 <<< FRAC_BITS);

   // Control state
   rsch_pkg::state_type state_ff, state_in;
   logic [1:0] k_ff,      k_in;
   logic [4:0] idx_ff,    idx_in;
   logic [4:0] cnt_ff,    cnt_in;
   logic [4:0] best_i_ff, best_i_in;
   logic       found_ff,  found_in;
   logic [4:0] count_ff,  count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [31:0] o_ff   [3], o_in   [3];
   logic signed [31:0] d_ff   [3], d_in   [3];
   logic signed [31:0] oc_ff  [3], oc_in  [3];
   logic signed [31:0] cen_ff [3], cen_in [3];
   logic signed [31:0] pt_ff  [3], pt_in  [3];
   logic signed [31:0] n_ff   [3], n_in   [3];
   logic signed [31:0] nrm_ff [3], nrm_in [3];
   logic [30:0]        rad_ff,    rad_in;
   logic signed [31:0] a_ff,      a_in;
   logic signed [31:0] h_ff,      h_in;
   logic signed [31:0] c_ff,      c_in;
   logic signed [31:0] best_t_ff, best_t_in;
   logic [31:0]        len_ff,    len_in;
   logic signed [63:0] prod_ff,   prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Response register
   logic               rsp_hit_ff,  rsp_hit_in;
   logic [3:0]         rsp_idx_ff,  rsp_idx_in;
   logic signed [31:0] rsp_dist_ff, rsp_dist_in;
   logic signed [31:0] rsp_pt_ff  [3], rsp_pt_in  [3];
   logic signed [31:0] rsp_nrm_ff [3], rsp_nrm_in [3];

   // Shared unit hookups
   rsch_pkg::unit_ctl_type sq_ctl, dv_ctl;
   rsch_pkg::unit_sts_type sq_sts, dv_sts;
   logic [63:0]            sq_rad;
   logic [31:0]            sq_root;
   logic [NUM_W-1:0]       dv_numer, dv_quot;
   logic [31:0]            dv_denom;

   // Table hookups
   rsch_pkg::sphere_type ram_wr, ram_rd;
   logic                 ram_we;
   logic [AW-1:0]        ram_rd_addr;
   logic signed [31:0]   rd_cen [3];

   // Multiplier operands
   logic signed [31:0] mul_a, mul_b;

   // Derived values
   logic                    req_fire, trace_fire, load_fire, rsp_go;
   logic signed [ACC_W-1:0] prod_ext, prod_sh;
   logic signed [ACC_W-1:0] acc_sum, acc_dif, acc_raw_sum, acc_raw_dif, pt_sum;
   logic signed [31:0]      a_new;
   logic signed [33:0]      num_t;
   logic                    last_k, last_sphere, a_bad, disc_neg, num_pos, len_zero;
   logic [31:0]             t_val, q32, mag;
   logic                    t_better;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign trace_fire = req_fire && (req_ch.action == rsch_pkg::ACT_TRACE);
   assign load_fire  = req_fire && (req_ch.action == rsch_pkg::ACT_LOAD);
   assign rsp_go     = !rsp_valid_ff || rsp_ch.ready;

   // Sphere table
   assign ram_we = load_fire && (int'(req_ch.slot) < MAX_SPHERES);
   always_comb begin
      ram_wr.cx     = req_ch.center_x;
      ram_wr.cy     = req_ch.center_y;
      ram_wr.cz     = req_ch.center_z;
      ram_wr.radius = req_ch.sphere_size;
   end

   rsch_ram #(
      .WIDTH($bits(rsch_pkg::sphere_type)),
      .DEPTH(MAX_SPHERES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(AW'(req_ch.slot)),
      .wr_data(ram_wr),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd)
   );

   assign rd_cen[0] = ram_rd.cx;
   assign rd_cen[1] = ram_rd.cy;
   assign rd_cen[2] = ram_rd.cz;

   rsch_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sq_ctl),
      .radicand(sq_rad),
      .sts     (sq_sts),
      .root    (sq_root)
   );

   rsch_div #(
      .NUM_W(NUM_W),
      .DEN_W(32)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .ctl  (dv_ctl),
      .numer(dv_numer),
      .denom(dv_denom),
      .sts  (dv_sts),
      .quot (dv_quot)
   );

   // Shared multiplier, registered product
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // Accumulator paths
   assign prod_ext    = ACC_W'(prod_ff);
   assign prod_sh     = prod_ext >>> FRAC_BITS;
   assign acc_sum     = acc_ff + prod_sh;
   assign acc_dif     = acc_ff - prod_sh;
   assign acc_raw_sum = acc_ff + prod_ext;
   assign acc_raw_dif = acc_ff - prod_ext;
   assign pt_sum      = ACC_W'(o_ff[k_ff]) + prod_sh;

   // Decisions
   assign a_new       = rsch_pkg::sat32(acc_sum);
   assign last_k      = k_ff == 2'd2;
   assign last_sphere = (6'(idx_ff) + 6'd1) == 6'(cnt_ff);
   assign a_bad       = a_new[31] || (a_new == 32'sd0) || (cnt_ff == 5'd0);
   assign disc_neg    = acc_raw_dif[ACC_W-1];
   assign num_t       = 34'(h_ff) - $signed({2'b00, sq_root});
   assign num_pos     = !num_t[33] && (num_t != 34'sd0);
   assign len_zero    = len_ff == 32'd0;
   assign t_val       = (|dv_quot[NUM_W-1:31]) ? 32'h7FFFFFFF : dv_quot[31:0];
   assign t_better    = (t_val != 32'd0) && (!found_ff || (t_val < $unsigned(best_t_ff)));
   assign q32         = dv_quot[31:0];
   assign mag         = n_ff[k_ff][31] ? (~n_ff[k_ff] + 32'd1) : n_ff[k_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsch_pkg::ST_IDLE:    if (trace_fire) state_in = rsch_pkg::ST_A_MUL;
         rsch_pkg::ST_A_MUL:   state_in = rsch_pkg::ST_A_ACC;
         rsch_pkg::ST_A_ACC: begin
            if (last_k) state_in = a_bad ? rsch_pkg::ST_OUT : rsch_pkg::ST_RD;
            else        state_in = rsch_pkg::ST_A_MUL;
         end
         rsch_pkg::ST_RD:      state_in = rsch_pkg::ST_OC;
         rsch_pkg::ST_OC:      state_in = rsch_pkg::ST_H_MUL;
         rsch_pkg::ST_H_MUL:   state_in = rsch_pkg::ST_H_ACC;
         rsch_pkg::ST_H_ACC:   state_in = last_k ? rsch_pkg::ST_C_MUL : rsch_pkg::ST_H_MUL;
         rsch_pkg::ST_C_MUL:   state_in = rsch_pkg::ST_C_ACC;
         rsch_pkg::ST_C_ACC:   state_in = last_k ? rsch_pkg::ST_R_MUL : rsch_pkg::ST_C_MUL;
         rsch_pkg::ST_R_MUL:   state_in = rsch_pkg::ST_R_ACC;
         rsch_pkg::ST_R_ACC:   state_in = rsch_pkg::ST_D_MUL1;
         rsch_pkg::ST_D_MUL1:  state_in = rsch_pkg::ST_D_ACC1;
         rsch_pkg::ST_D_ACC1:  state_in = rsch_pkg::ST_D_MUL2;
         rsch_pkg::ST_D_MUL2:  state_in = rsch_pkg::ST_D_ACC2;
         rsch_pkg::ST_D_ACC2:  state_in = disc_neg ? rsch_pkg::ST_NEXT : rsch_pkg::ST_SQ_RUN;
         rsch_pkg::ST_SQ_RUN: begin
            if (sq_sts.done) state_in = num_pos ? rsch_pkg::ST_T_DIV : rsch_pkg::ST_NEXT;
         end
         rsch_pkg::ST_T_DIV:   if (dv_sts.done) state_in = rsch_pkg::ST_NEXT;
         rsch_pkg::ST_NEXT: begin
            if (!last_sphere)  state_in = rsch_pkg::ST_RD;
            else if (found_ff) state_in = rsch_pkg::ST_F_RD;
            else               state_in = rsch_pkg::ST_OUT;
         end
         rsch_pkg::ST_F_RD:    state_in = rsch_pkg::ST_F_CEN;
         rsch_pkg::ST_F_CEN:   state_in = rsch_pkg::ST_P_MUL;
         rsch_pkg::ST_P_MUL:   state_in = rsch_pkg::ST_P_ACC;
         rsch_pkg::ST_P_ACC:   state_in = last_k ? rsch_pkg::ST_N_SUB : rsch_pkg::ST_P_MUL;
         rsch_pkg::ST_N_SUB:   state_in = rsch_pkg::ST_L_MUL;
         rsch_pkg::ST_L_MUL:   state_in = rsch_pkg::ST_L_ACC;
         rsch_pkg::ST_L_ACC:   state_in = last_k ? rsch_pkg::ST_L_SQ : rsch_pkg::ST_L_MUL;
         rsch_pkg::ST_L_SQ:    if (sq_sts.done) state_in = rsch_pkg::ST_NRM;
         rsch_pkg::ST_NRM: begin
            if (!len_zero)   state_in = rsch_pkg::ST_NRM_DIV;
            else if (last_k) state_in = rsch_pkg::ST_OUT;
         end
         rsch_pkg::ST_NRM_DIV: begin
            if (dv_sts.done) state_in = last_k ? rsch_pkg::ST_OUT : rsch_pkg::ST_NRM;
         end
         rsch_pkg::ST_OUT:     if (rsp_go) state_in = rsch_pkg::ST_IDLE;
         default:              state_in = rsch_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, table address, unit operands and starts
   always_comb begin
      req_ch.ready = state_ff == rsch_pkg::ST_IDLE;
      csr_ch.ready = 1'b1;
      ram_rd_addr  = (state_ff == rsch_pkg::ST_F_RD) ? AW'(best_i_ff) : AW'(idx_ff);
      mul_a        = d_ff[k_ff];
      mul_b        = d_ff[k_ff];
      sq_ctl.start = 1'b0;
      sq_rad       = acc_raw_dif[63:0];
      dv_ctl.start = 1'b0;
      dv_numer     = {1'b0, num_t[30:0], {FRAC_BITS{1'b0}}};
      dv_denom     = {1'b0, a_ff[30:0]};
      case (state_ff)
         rsch_pkg::ST_H_MUL: begin
            mul_b = oc_ff[k_ff];
         end
         rsch_pkg::ST_C_MUL: begin
            mul_a = oc_ff[k_ff];
            mul_b = oc_ff[k_ff];
         end
         rsch_pkg::ST_R_MUL: begin
            mul_a = $signed({1'b0, rad_ff});
            mul_b = $signed({1'b0, rad_ff});
         end
         rsch_pkg::ST_D_MUL1: begin
            mul_a = h_ff;
            mul_b = h_ff;
         end
         rsch_pkg::ST_D_MUL2: begin
            mul_a = a_ff;
            mul_b = c_ff;
         end
         rsch_pkg::ST_P_MUL: begin
            mul_b = best_t_ff;
         end
         rsch_pkg::ST_L_MUL: begin
            mul_a = n_ff[k_ff];
            mul_b = n_ff[k_ff];
         end
         rsch_pkg::ST_D_ACC2: begin
            sq_ctl.start = !disc_neg;
         end
         rsch_pkg::ST_L_ACC: begin
            sq_rad       = acc_raw_sum[63:0];
            sq_ctl.start = last_k;
         end
         rsch_pkg::ST_SQ_RUN: begin
            dv_ctl.start = sq_sts.done && num_pos;
         end
         rsch_pkg::ST_NRM: begin
            dv_numer     = {mag, {FRAC_BITS{1'b0}}};
            dv_denom     = len_ff;
            dv_ctl.start = !len_zero;
         end
         default: begin
         end
      endcase
   end

   // Datapath updates
   always_comb begin
      k_in        = k_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      best_i_in   = best_i_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      o_in        = o_ff;
      d_in        = d_ff;
      oc_in       = oc_ff;
      cen_in      = cen_ff;
      pt_in       = pt_ff;
      n_in        = n_ff;
      nrm_in      = nrm_ff;
      rad_in      = rad_ff;
      a_in        = a_ff;
      h_in        = h_ff;
      c_in        = c_ff;
      best_t_in   = best_t_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_pt_in   = rsp_pt_ff;
      rsp_nrm_in  = rsp_nrm_ff;

      // Count register write
      if (csr_ch.valid && csr_ch.ready) begin
         count_in = csr_ch.data;
      end

      // Drop a response once it is taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rsch_pkg::ST_IDLE: begin
            if (trace_fire) begin
               o_in[0]  = req_ch.origin_x;
               o_in[1]  = req_ch.origin_y;
               o_in[2]  = req_ch.origin_z;
               d_in[0]  = req_ch.dir_x;
               d_in[1]  = req_ch.dir_y;
               d_in[2]  = req_ch.dir_z;
               cnt_in   = (int'(count_ff) > MAX_SPHERES) ? 5'(MAX_SPHERES) : count_ff;
               idx_in   = '0;
               k_in     = '0;
               found_in = 1'b0;
               acc_in   = '0;
            end
         end
         rsch_pkg::ST_A_ACC: begin
            acc_in = acc_sum;
            k_in   = k_ff + 2'd1;
            if (last_k) begin
               a_in   = a_new;
               acc_in = '0;
               k_in   = '0;
            end
         end
         rsch_pkg::ST_OC: begin
            for (int j = 0; j < 3; j++) begin
               oc_in[j] = rsch_pkg::sat32(ACC_W'(rd_cen[j]) - ACC_W'(o_ff[j]));
            end
            rad_in = ram_rd.radius;
         end
         rsch_pkg::ST_H_ACC: begin
            acc_in = acc_sum;
            k_in   = k_ff + 2'd1;
            if (last_k) begin
               h_in   = rsch_pkg::sat32(acc_sum);
               acc_in = '0;
               k_in   = '0;
            end
         end
         rsch_pkg::ST_C_ACC: begin
            acc_in = acc_sum;
            k_in   = last_k ? 2'd0 : k_ff + 2'd1;
         end
         rsch_pkg::ST_R_ACC: begin
            c_in   = rsch_pkg::sat32(acc_dif);
            acc_in = '0;
         end
         rsch_pkg::ST_D_ACC1: begin
            acc_in = acc_raw_sum;
         end
         rsch_pkg::ST_D_ACC2: begin
            acc_in = '0;
         end
         rsch_pkg::ST_T_DIV: begin
            if (dv_sts.done && t_better) begin
               found_in  = 1'b1;
               best_t_in = $signed(t_val);
               best_i_in = idx_ff;
            end
         end
         rsch_pkg::ST_NEXT: begin
            idx_in = idx_ff + 5'd1;
         end
         rsch_pkg::ST_F_CEN: begin
            cen_in = rd_cen;
         end
         rsch_pkg::ST_P_ACC: begin
            pt_in[k_ff] = rsch_pkg::sat32(pt_sum);
            k_in        = last_k ? 2'd0 : k_ff + 2'd1;
         end
         rsch_pkg::ST_N_SUB: begin
            for (int j = 0; j < 3; j++) begin
               n_in[j] = rsch_pkg::sat32(ACC_W'(pt_ff[j]) - ACC_W'(cen_ff[j]));
            end
         end
         rsch_pkg::ST_L_ACC: begin
            acc_in = acc_raw_sum;
            k_in   = k_ff + 2'd1;
            if (last_k) begin
               acc_in = '0;
               k_in   = '0;
            end
         end
         rsch_pkg::ST_L_SQ: begin
            if (sq_sts.done) begin
               len_in = sq_root;
            end
         end
         rsch_pkg::ST_NRM: begin
            if (len_zero) begin
               nrm_in[k_ff] = '0;
               k_in         = last_k ? 2'd0 : k_ff + 2'd1;
            end
         end
         rsch_pkg::ST_NRM_DIV: begin
            if (dv_sts.done) begin
               nrm_in[k_ff] = n_ff[k_ff][31] ? $signed(~q32 + 32'd1) : $signed(q32);
               k_in         = last_k ? 2'd0 : k_ff + 2'd1;
            end
         end
         rsch_pkg::ST_OUT: begin
            if (rsp_go) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_hit_in  = 1'b1;
                  rsp_idx_in  = 4'(best_i_ff);
                  rsp_dist_in = best_t_ff;
                  rsp_pt_in   = pt_ff;
                  rsp_nrm_in  = nrm_ff;
               end else begin
                  rsp_hit_in  = 1'b0;
                  rsp_idx_in  = '0;
                  rsp_dist_in = MISS_DIST;
                  for (int j = 0; j < 3; j++) begin
                     rsp_pt_in[j]  = '0;
                     rsp_nrm_in[j] = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsch_pkg::ST_IDLE;
         k_ff         <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         best_i_ff    <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         best_i_ff    <= best_i_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      o_ff        <= o_in;
      d_ff        <= d_in;
      oc_ff       <= oc_in;
      cen_ff      <= cen_in;
      pt_ff       <= pt_in;
      n_ff        <= n_in;
      nrm_ff      <= nrm_in;
      rad_ff      <= rad_in;
      a_ff        <= a_in;
      h_ff        <= h_in;
      c_ff        <= c_in;
      best_t_ff   <= best_t_in;
      len_ff      <= len_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_nrm_ff  <= rsp_nrm_in;
   end

   // Response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.hit_index    = rsp_idx_ff;
   assign rsp_ch.hit_distance = rsp_dist_ff;
   assign rsp_ch.point_x      = rsp_pt_ff[0];
   assign rsp_ch.point_y      = rsp_pt_ff[1];
   assign rsp_ch.point_z      = rsp_pt_ff[2];
   assign rsp_ch.normal_x     = rsp_nrm_ff[0];
   assign rsp_ch.normal_y     = rsp_nrm_ff[1];
   assign rsp_ch.normal_z     = rsp_nrm_ff[2];

   // Square root and divider never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sq_sts.busy && dv_sts.busy))
      else $error("square root and divider busy at once");

   // A unit is started only while both units are idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (sq_ctl.start || dv_ctl.start) |-> (!sq_sts.busy && !dv_sts.busy))
      else $error("iterative unit started while busy");

   // A miss response carries the miss distance
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_dist_ff == MISS_DIST))
      else $error("miss response with wrong distance");

   // A taken response clears unless a new one is loaded behind it
   a_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.ready && state_ff != rsch_pkg::ST_OUT) |=> !rsp_valid_ff)
      else $error("response repeated after transaction");

endmodule
